### src/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// shared types and constants for the motion point queue
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int SIZE_W          = 5;
    localparam int CAP_W           = 5;
    localparam int CNT_W           = 32;
    localparam int CFG_ADDR_W      = 1;
    localparam int CFG_DATA_W      = 5;
    localparam int S_TDATA_W       = 72;
    localparam int M_TDATA_W       = 136;
    localparam int M_TUSER_W       = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_POLICY   = 1'b1;

    typedef enum logic [1:0] {
        MODE_ENQUEUE  = 2'd0,
        MODE_DISPATCH = 2'd1,
        MODE_REQUEUE  = 2'd2,
        MODE_CLEAR    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        POL_REJECT       = 2'd0,
        POL_DROP_NEWEST  = 2'd1,
        POL_DROP_OLDEST  = 2'd2,
        POL_REPLACE_LAST = 2'd3
    } policy_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_UNUSED = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic               relative;
        logic               has_speed;
        logic [15:0]        speed;
        logic               has_accel;
        logic [14:0]        accel;
    } point_t;

    typedef struct packed {
        logic              shift_fwd;
        logic              shift_back;
        logic              load_en;
        logic [SIZE_W-1:0] load_idx;
    } cell_ctrl_t;

    typedef struct packed {
        status_t           status;
        logic              point_valid;
        logic [SIZE_W-1:0] queue_size;
        logic [CNT_W-1:0]  pushed_count;
        logic [CNT_W-1:0]  dropped_count;
    } result_t;

endpackage

### src/motion_point_queue_with_overflow_policy.sv
// ----------------------------------------------------------------------------
// motion_point_queue_with_overflow_policy
// bounded motion point queue with selectable overflow policy
// result: registered in the output register at the edge of the input transfer
// throughput: one operation per cycle unless a held result stalls s_tready,
//   set by the count update and the one-step shift of the cell chain
// reset: count and totals cleared, capacity 16, policy reject; cells not cleared
// ----------------------------------------------------------------------------
module motion_point_queue_with_overflow_policy
    import mpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // position, relative, has_speed, speed, has_accel, accel, zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // mode
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_position, out_relative, out_has_speed, out_speed, out_has_accel,
    // out_accel, queue_size, pushed_count, dropped_count, zero pad
    output logic [M_TDATA_W-1:0]  m_tdata,
    // status, point_valid
    output logic [M_TUSER_W-1:0]  m_tuser
);

    logic       fire;
    point_t     point_in;
    cell_ctrl_t cell_ctrl;
    result_t    result;
    point_t     cell_q [QUEUE_DEPTH];
    point_t     out_point;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_res_reg;
    point_t     out_point_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    assign point_in.position  = s_tdata[31:0];
    assign point_in.relative  = s_tdata[32];
    assign point_in.has_speed = s_tdata[33];
    assign point_in.speed     = s_tdata[49:34];
    assign point_in.has_accel = s_tdata[50];
    assign point_in.accel     = s_tdata[65:51];

    mpq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .mode      (mode_t'(s_tuser)),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cell_ctrl (cell_ctrl),
        .result    (result)
    );

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        mpq_cell #(
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl),
            .point_in (point_in),
            .left_q   (cell_q[(i == 0) ? 0 : i - 1]),
            .right_q  (cell_q[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
            .q        (cell_q[i])
        );
    end

    always_comb
    begin
        out_point = '0;
        if (result.point_valid)
        begin
            out_point = cell_q[0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_res_reg   <= result;
            out_point_reg <= out_point;
        end
    end

    assign m_tvalid = out_valid_reg;

    assign m_tdata[31:0]    = out_point_reg.position;
    assign m_tdata[32]      = out_point_reg.relative;
    assign m_tdata[33]      = out_point_reg.has_speed;
    assign m_tdata[49:34]   = out_point_reg.speed;
    assign m_tdata[50]      = out_point_reg.has_accel;
    assign m_tdata[65:51]   = out_point_reg.accel;
    assign m_tdata[70:66]   = out_res_reg.queue_size;
    assign m_tdata[102:71]  = out_res_reg.pushed_count;
    assign m_tdata[134:103] = out_res_reg.dropped_count;
    assign m_tdata[135]     = 1'b0;

    assign m_tuser[1:0] = out_res_reg.status;
    assign m_tuser[2]   = out_res_reg.point_valid;

endmodule

### src/mpq_cell.sv
// ----------------------------------------------------------------------------
// mpq_cell
// one queue slot: loads a new point or takes its neighbor's entry
// ----------------------------------------------------------------------------
module mpq_cell
    import mpq_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  point_t     point_in,
    input  point_t     left_q,
    input  point_t     right_q,
    output point_t     q
);

    point_t entry_reg;
    point_t entry_next;
    logic   load_here;

    assign load_here = ctrl.load_en && (int'(ctrl.load_idx) == INDEX);

    always_comb
    begin
        entry_next = entry_reg;
        if (load_here)
        begin
            entry_next = point_in;
        end
        else if (ctrl.shift_fwd)
        begin
            entry_next = right_q;
        end
        else if (ctrl.shift_back)
        begin
            entry_next = left_q;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

### src/mpq_ctrl.sv
// ----------------------------------------------------------------------------
// mpq_ctrl
// fill count, totals, config registers and per-operation cell control
// ----------------------------------------------------------------------------
module mpq_ctrl
    import mpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  mode_t                 mode,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cell_ctrl_t            cell_ctrl,
    output result_t               result
);

    localparam int CAP_MAX = (QUEUE_DEPTH < 31) ? QUEUE_DEPTH : 31;

    logic [SIZE_W-1:0] count_reg;
    logic [SIZE_W-1:0] count_next;
    logic [CNT_W-1:0]  pushed_reg;
    logic [CNT_W-1:0]  pushed_next;
    logic [CNT_W-1:0]  dropped_reg;
    logic [CNT_W-1:0]  dropped_next;
    logic [CAP_W-1:0]  cap_reg;
    policy_t           policy_reg;
    logic [SIZE_W-1:0] cap_eff;
    logic              full;
    status_t           status;
    logic              point_valid;
    cell_ctrl_t        op;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = SIZE_W'(1);
        end
        else if (int'(cap_reg) > CAP_MAX)
        begin
            cap_eff = SIZE_W'(CAP_MAX);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign full = (count_reg >= cap_eff);

    always_comb
    begin
        count_next   = count_reg;
        pushed_next  = pushed_reg;
        dropped_next = dropped_reg;
        status       = ST_OK;
        point_valid  = 1'b0;
        op           = '0;
        case (mode)
            MODE_ENQUEUE:
            begin
                if (policy_reg == POL_REPLACE_LAST)
                begin
                    op.load_en  = 1'b1;
                    op.load_idx = '0;
                    count_next  = SIZE_W'(1);
                    pushed_next = pushed_reg + 1'b1;
                end
                else if (full)
                begin
                    case (policy_reg)
                        POL_DROP_NEWEST:
                        begin
                            dropped_next = dropped_reg + 1'b1;
                        end
                        POL_DROP_OLDEST:
                        begin
                            op.shift_fwd = 1'b1;
                            op.load_en   = 1'b1;
                            op.load_idx  = count_reg - 1'b1;
                            dropped_next = dropped_reg + 1'b1;
                            pushed_next  = pushed_reg + 1'b1;
                        end
                        default:
                        begin
                            status = ST_FULL;
                        end
                    endcase
                end
                else
                begin
                    op.load_en  = 1'b1;
                    op.load_idx = count_reg;
                    count_next  = count_reg + 1'b1;
                    pushed_next = pushed_reg + 1'b1;
                end
            end
            MODE_DISPATCH:
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    point_valid  = 1'b1;
                    op.shift_fwd = 1'b1;
                    count_next   = count_reg - 1'b1;
                end
            end
            MODE_REQUEUE:
            begin
                if (full && policy_reg == POL_DROP_NEWEST)
                begin
                    dropped_next = dropped_reg + 1'b1;
                end
                else if (full && policy_reg == POL_REPLACE_LAST)
                begin
                    op.load_en  = 1'b1;
                    op.load_idx = '0;
                    count_next  = SIZE_W'(1);
                end
                else if (full)
                begin
                    // newest entry falls off the back
                    op.shift_back = 1'b1;
                    op.load_en    = 1'b1;
                    op.load_idx   = '0;
                    dropped_next  = dropped_reg + 1'b1;
                end
                else
                begin
                    op.shift_back = 1'b1;
                    op.load_en    = 1'b1;
                    op.load_idx   = '0;
                    count_next    = count_reg + 1'b1;
                end
            end
            default:
            begin
                count_next = '0;
            end
        endcase
    end

    always_comb
    begin
        cell_ctrl = op;
        if (!fire)
        begin
            cell_ctrl = '0;
        end
    end

    assign result.status        = status;
    assign result.point_valid   = point_valid;
    assign result.queue_size    = count_next;
    assign result.pushed_count  = pushed_next;
    assign result.dropped_count = dropped_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pushed_reg  <= '0;
            dropped_reg <= '0;
            cap_reg     <= CAP_W'(16);
            policy_reg  <= POL_REJECT;
        end
        else
        begin
            if (fire)
            begin
                count_reg   <= count_next;
                pushed_reg  <= pushed_next;
                dropped_reg <= dropped_next;
            end
            if (cfg_we && cfg_addr == CFG_CAPACITY)
            begin
                cap_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == CFG_POLICY)
            begin
                policy_reg <= policy_t'(cfg_wdata[1:0]);
            end
        end
    end

endmodule

### dv/tb_motion_point_queue_with_overflow_policy.sv
// ----------------------------------------------------------------------------
// tb_motion_point_queue_with_overflow_policy
// self-checking bench for the motion point queue: a cycle-free copy of the
// queue predicts status, dispatched point, size and totals for every accepted
// operation; the output stream is checked in order against those predictions
// under random stalls on both sides, a long output hold-off and several
// capacity and overflow policy settings
// ----------------------------------------------------------------------------
module tb_motion_point_queue_with_overflow_policy;
    import mpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = QUEUE_DEPTH_DEF;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        status_t     status;
        logic        point_valid;
        point_t      pt;
        logic [4:0]  size;
        logic [31:0] pushed;
        logic [31:0] dropped;
    } outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    // predicted queue contents and settings
    point_t      ring_point [DEPTH];
    logic [3:0]  ring_head = '0;
    int          ring_held = 0;
    logic [31:0] total_pushed = '0;
    logic [31:0] total_dropped = '0;
    logic [4:0]  cfg_capacity = 5'd16;
    policy_t     cfg_policy = POL_REJECT;

    outcome_t pending_outcomes [$];
    int       mismatches = 0;
    int       cycles = 0;
    bit       idle_en = 1'b1;
    int       hold_left = 0;
    int       stall_left = 0;

    motion_point_queue_with_overflow_policy dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLE)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void append_point(point_t p);
        ring_point[ring_head + 4'(ring_held)] = p;
        ring_held++;
        total_pushed++;
    endfunction

    function automatic outcome_t predict_queue_op(mode_t m, point_t p);
        outcome_t r;
        int       cap;
        bit       full;
        bit       keep;
        r = '0;
        r.status = ST_OK;
        cap = (cfg_capacity == 0) ? 1 : ((cfg_capacity > DEPTH) ? DEPTH : int'(cfg_capacity));
        full = ring_held >= cap;
        case (m)
            MODE_ENQUEUE:
            begin
                if (cfg_policy == POL_REPLACE_LAST)
                begin
                    ring_held = 0;
                    append_point(p);
                end
                else if (full)
                begin
                    if (cfg_policy == POL_DROP_NEWEST)
                        total_dropped++;
                    else if (cfg_policy == POL_DROP_OLDEST)
                    begin
                        ring_head++;
                        ring_held--;
                        total_dropped++;
                        append_point(p);
                    end
                    else
                        r.status = ST_FULL;
                end
                else
                    append_point(p);
            end
            MODE_DISPATCH:
            begin
                if (ring_held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.point_valid = 1'b1;
                    r.pt = ring_point[ring_head];
                    ring_head++;
                    ring_held--;
                end
            end
            MODE_REQUEUE:
            begin
                keep = 1'b1;
                if (full)
                begin
                    if (cfg_policy == POL_DROP_NEWEST)
                    begin
                        total_dropped++;
                        keep = 1'b0;
                    end
                    else if (cfg_policy == POL_REPLACE_LAST)
                        ring_held = 0;
                    else if (ring_held > 0)
                    begin
                        ring_held--;
                        total_dropped++;
                    end
                end
                if (keep)
                begin
                    ring_head--;
                    ring_point[ring_head] = p;
                    ring_held++;
                end
            end
            default:
                ring_held = 0;
        endcase
        r.size = 5'(ring_held);
        r.pushed = total_pushed;
        r.dropped = total_dropped;
        return r;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", what, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        outcome_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result transfer with no operation pending");
            end
            else
            begin
                w = pending_outcomes[0];
                pending_outcomes.delete(0);
                check_field("status", 32'(w.status), 32'(m_tuser[1:0]));
                check_field("point_valid", 32'(w.point_valid), 32'(m_tuser[2]));
                check_field("position", w.pt.position, m_tdata[31:0]);
                check_field("relative", 32'(w.pt.relative), 32'(m_tdata[32]));
                check_field("has_speed", 32'(w.pt.has_speed), 32'(m_tdata[33]));
                check_field("speed", 32'(w.pt.speed), 32'(m_tdata[49:34]));
                check_field("has_accel", 32'(w.pt.has_accel), 32'(m_tdata[50]));
                check_field("accel", 32'(w.pt.accel), 32'(m_tdata[65:51]));
                check_field("queue_size", 32'(w.size), 32'(m_tdata[70:66]));
                check_field("pushed_count", w.pushed, m_tdata[102:71]);
                check_field("dropped_count", w.dropped, m_tdata[134:103]);
            end
        end
    end

    // receiver: long hold-off when requested, otherwise random stall bursts while idle_en is set
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (stall_left == 0 && idle_en && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 17);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic point_t make_point(logic [31:0] pos, logic rel, logic hs,
                                          logic [15:0] spd, logic ha, logic [14:0] acc);
        point_t p;
        p.position = pos;
        p.relative = rel;
        p.has_speed = hs;
        p.speed = spd;
        p.has_accel = ha;
        p.accel = acc;
        return p;
    endfunction

    function automatic point_t rand_point();
        logic [31:0] pos;
        logic [14:0] acc;
        case ($urandom_range(0, 9))
            0:       pos = 32'h8000_0000;
            1:       pos = 32'h7fff_ffff;
            default: pos = $urandom;
        endcase
        acc = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 25600));
        return make_point(pos, 1'($urandom), 1'($urandom), 16'($urandom), 1'($urandom), acc);
    endfunction

    task automatic send_op(mode_t m, point_t p);
        int       gap;
        outcome_t o;
        @(negedge clk);
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= m;
        s_tdata <= {6'b0, p.accel, p.has_accel, p.speed, p.has_speed,
                    p.relative, p.position};
        do
            @(posedge clk);
        while (!s_tready);
        o = predict_queue_op(m, p);
        pending_outcomes = {pending_outcomes, o};
    endtask

    task automatic wait_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        if (addr == CFG_CAPACITY)
            cfg_capacity = data;
        else
            cfg_policy = policy_t'(data[1:0]);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // queue is left as it is, so a lower capacity may meet a fuller queue
    task automatic configure(logic [4:0] cap, policy_t pol);
        wait_drain();
        write_reg(CFG_CAPACITY, cap);
        write_reg(CFG_POLICY, {3'($urandom), pol});
    endtask

    task automatic run_ops(int n, int enq_pct);
        int    r;
        mode_t m;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < enq_pct)
                m = MODE_ENQUEUE;
            else if (r < 88)
                m = MODE_DISPATCH;
            else if (r < 96)
                m = MODE_REQUEUE;
            else
                m = MODE_CLEAR;
            send_op(m, rand_point());
        end
    endtask

    task automatic test_reset_and_extremes();
        send_op(MODE_DISPATCH, rand_point());
        send_op(MODE_ENQUEUE, make_point(32'h8000_0000, 1'b0, 1'b0, 16'h0000, 1'b0, 15'd0));
        send_op(MODE_ENQUEUE, make_point(32'h7fff_ffff, 1'b1, 1'b1, 16'hffff, 1'b1, 15'd25600));
        send_op(MODE_ENQUEUE, make_point(32'hffff_ffff, 1'b1, 1'b0, 16'h8001, 1'b1, 15'h7fff));
        send_op(MODE_REQUEUE, make_point(32'h0001_0000, 1'b0, 1'b1, 16'h1234, 1'b0, 15'h2aaa));
        repeat (4) send_op(MODE_DISPATCH, rand_point());
        send_op(MODE_ENQUEUE, rand_point());
        send_op(MODE_CLEAR, rand_point());
        send_op(MODE_DISPATCH, rand_point());
    endtask

    task automatic test_overflow_policies();
        policy_t pol;
        for (int i = 0; i < 4; i++)
        begin
            pol = policy_t'(i);
            configure((i % 2 == 0) ? 5'd0 : 5'd1, pol);
            send_op(MODE_ENQUEUE, rand_point());
            send_op(MODE_ENQUEUE, rand_point());
            send_op(MODE_REQUEUE, rand_point());
            send_op(MODE_DISPATCH, rand_point());
        end
    endtask

    task automatic test_output_hold_off();
        configure(5'd16, POL_REJECT);
        @(negedge clk);
        hold_left = 300;
        run_ops(40, 70);
    endtask

    task automatic test_random_phases();
        configure(5'd31, POL_REJECT);
        run_ops(90, 70);
        configure(5'd3, POL_DROP_NEWEST);
        run_ops(60, 55);
        configure(5'd16, POL_DROP_OLDEST);
        run_ops(90, 70);
        configure(5'd0, POL_REPLACE_LAST);
        run_ops(50, 50);
        for (int i = 0; i < 8; i++)
        begin
            configure(5'($urandom), policy_t'($urandom_range(0, 3)));
            run_ops(70, $urandom_range(40, 70));
        end
    endtask

    task automatic test_random_no_idle();
        idle_en = 1'b0;
        configure(5'($urandom_range(1, 8)), policy_t'($urandom_range(0, 3)));
        run_ops(150, 55);
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_and_extremes();
        test_overflow_policies();
        test_output_hold_off();
        test_random_phases();
        test_random_no_idle();
        wait_drain();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
src/mpq_pkg.sv
src/mpq_cell.sv
src/mpq_ctrl.sv
src/motion_point_queue_with_overflow_policy.sv
dv/tb_motion_point_queue_with_overflow_policy.sv
